[src/voltage_drop_mismatch_estimator_top_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros for the mismatch estimator
// same-cycle and next-cycle implication checks, reset masked
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_DROP_MISMATCH_ESTIMATOR_TOP_MACROS_SVH
`define VOLTAGE_DROP_MISMATCH_ESTIMATOR_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VDME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vdme same-cycle check failed");

// antecedent implies consequent in the following cycle
`define VDME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vdme next-cycle check failed");

`endif

[src/vdme_pkg.sv]
// ----------------------------------------------------------------------------
// vdme_pkg
// shared constants, beat types and controller interface for the estimator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdme_pkg;

    // build constants
    localparam int WINDOW_DEPTH  = 4;
    localparam int FRACTION_BITS = 8;
    localparam int VOLTAGE_BITS  = 12;

    // fixed field widths
    localparam int OP_W    = 1;
    localparam int VIN_W   = 12;
    localparam int EST_W   = 11;
    localparam int LEVEL_W = 12;

    // derived widths
    localparam int DROP_SHIFT = 2;                          // scale of 4
    localparam int FIG_W      = FRACTION_BITS + 3;          // holds up to 5.0
    localparam int QBITS      = FRACTION_BITS + DROP_SHIFT; // quotient below 4.0
    localparam int CNT_W      = $clog2(QBITS);
    localparam int PTR_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W      = FIG_W + PTR_W;

    localparam logic [FIG_W-1:0] FIX_ONE = FIG_W'(1) << FRACTION_BITS;
    localparam logic [FIG_W-1:0] FIX_MIN = FIX_ONE;
    localparam logic [FIG_W-1:0] FIX_MAX = FIG_W'(5) << FRACTION_BITS;

    localparam logic OP_IDLE = 1'b0;
    localparam logic OP_TX   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [VIN_W-1:0] voltage;
    } t_in_beat;

    typedef struct packed {
        logic [EST_W-1:0]   estimate;
        logic [LEVEL_W-1:0] idle_level;
        logic [LEVEL_W-1:0] tx_level;
        logic               updated;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_AVG,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;   // latch input beat, update stores
        logic step;     // one restoring division step
        logic push;     // write figure into ring
        logic avg;      // recompute ring mean
        logic load;     // capture result beat
    } t_cmd;

    typedef struct packed {
        logic update;   // incoming beat will produce a new figure
        logic div_last; // final quotient bit this cycle
    } t_status;

endpackage

[src/vdme_dp.sv]
// ----------------------------------------------------------------------------
// vdme_dp
// datapath: voltage stores, restoring divider, figure ring and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdme_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vdme_pkg::t_cmd      i_cmd,
    output vdme_pkg::t_status   o_status,
    input  vdme_pkg::t_in_beat  i_in_beat,
    output vdme_pkg::t_out_beat o_out_beat
);
    import vdme_pkg::*;

    logic [VOLTAGE_BITS-1:0] r_idle, n_idle;
    logic [VOLTAGE_BITS-1:0] r_tx, n_tx;
    logic [VOLTAGE_BITS-1:0] r_rem, n_rem;
    logic [QBITS-1:0]        r_quo, n_quo;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [FIG_W-1:0]        r_ring [WINDOW_DEPTH];
    logic [PTR_W-1:0]        r_ptr, n_ptr;
    logic [FIG_W-1:0]        r_avg, n_avg;
    logic                    r_upd, n_upd;
    t_out_beat               r_out, n_out;

    logic [VOLTAGE_BITS-1:0] v_in;
    logic [VOLTAGE_BITS:0]   rem_sh;
    logic [VOLTAGE_BITS:0]   trial;
    logic                    qbit;
    logic [FIG_W-1:0]        fig_raw;
    logic [FIG_W-1:0]        fig;
    logic [SUM_W-1:0]        sum;

    assign v_in = i_in_beat.voltage[VOLTAGE_BITS-1:0];

    assign o_status.update = (i_in_beat.operation == OP_TX) && (r_idle != '0)
                             && (v_in != '0) && (v_in < r_idle);
    assign o_status.div_last = (r_cnt == CNT_W'(QBITS - 1));

    // restoring step, remainder always below the idle level
    assign rem_sh = {r_rem, 1'b0};
    assign trial  = rem_sh - {1'b0, r_idle};
    assign qbit   = (rem_sh >= {1'b0, r_idle});

    always_comb begin
        fig_raw = FIX_ONE + FIG_W'(r_quo);
        if (fig_raw < FIX_MIN) begin
            fig = FIX_MIN;
        end else if (fig_raw > FIX_MAX) begin
            fig = FIX_MAX;
        end else begin
            fig = fig_raw;
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            sum = sum + SUM_W'(r_ring[i]);
        end
    end

    always_comb begin
        n_idle = r_idle;
        n_tx   = r_tx;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_ptr  = r_ptr;
        n_avg  = r_avg;
        n_upd  = r_upd;
        n_out  = r_out;
        if (i_cmd.accept) begin
            if (i_in_beat.operation == OP_IDLE) begin
                n_idle = v_in;
            end else begin
                n_tx = v_in;
            end
            n_rem = r_idle - v_in;
            n_quo = '0;
            n_cnt = '0;
            n_upd = o_status.update;
        end
        if (i_cmd.step) begin
            n_rem = qbit ? trial[VOLTAGE_BITS-1:0] : rem_sh[VOLTAGE_BITS-1:0];
            n_quo = {r_quo[QBITS-2:0], qbit};
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (i_cmd.push) begin
            n_ptr = (r_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
        end
        if (i_cmd.avg) begin
            n_avg = FIG_W'(sum / WINDOW_DEPTH);
        end
        if (i_cmd.load) begin
            n_out.estimate   = EST_W'(r_avg);
            n_out.idle_level = LEVEL_W'(r_idle);
            n_out.tx_level   = LEVEL_W'(r_tx);
            n_out.updated    = r_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
            r_tx   <= '0;
            r_cnt  <= '0;
            r_ptr  <= '0;
            r_avg  <= FIX_ONE;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_ring[i] <= FIX_ONE;
            end
        end else begin
            r_idle <= n_idle;
            r_tx   <= n_tx;
            r_cnt  <= n_cnt;
            r_ptr  <= n_ptr;
            r_avg  <= n_avg;
            if (i_cmd.push) begin
                r_ring[r_ptr] <= fig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_upd <= n_upd;
        r_out <= n_out;
    end

    assign o_out_beat = r_out;

endmodule

[src/vdme_ctrl.sv]
// ----------------------------------------------------------------------------
// vdme_ctrl
// controller: sequences accept, divide, ring push, mean and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voltage_drop_mismatch_estimator_top_macros.svh"

module vdme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  vdme_pkg::t_status i_status,
    output vdme_pkg::t_cmd    o_cmd
);
    import vdme_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.update ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = S_AVG;
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `VDME_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.load, !r_out_valid || i_out_ready)
    `VDME_ASSERT_NEXT(a_div_to_push, i_clk, i_rst_n, r_state == S_DIV && i_status.div_last, r_state == S_PUSH)
    `VDME_ASSERT_NEXT(a_no_update_skips, i_clk, i_rst_n, o_cmd.accept && !i_status.update, r_state == S_DONE)
    `VDME_ASSERT_NEXT(a_load_gives_valid, i_clk, i_rst_n, o_cmd.load, o_out_valid && r_state == S_IDLE)

endmodule

[src/voltage_drop_mismatch_estimator_top.sv]
// ----------------------------------------------------------------------------
// voltage_drop_mismatch_estimator_top
// battery sag mismatch estimator: stores idle and transmit levels, forms
// 1 + 4*(idle-tx)/idle per transmit sample below idle and averages the last four
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | beat
//  in      | input     | i_in_valid / o_in_ready   | operation, voltage
//  out     | output    | o_out_valid / i_out_ready | estimate, idle_level, tx_level, updated
//
//  a beat that adds to the ring passes from acceptance to the result register
//  through accept, the restoring divider (one quotient bit a cycle), the ring
//  write, the mean and the load; a beat that adds nothing goes straight from
//  accept to load
//  reset is synchronous and active low; it clears both stores, fills the ring
//  and the mean with 1.0 (no clearing pass); the result register is not reset
//  a result waiting for i_out_ready does not block the next input beat; the
//  block stalls only when that next result is ready and the slot is still full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voltage_drop_mismatch_estimator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vdme_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vdme_pkg::t_out_beat o_out_beat
);
    import vdme_pkg::*;

    // command and status between controller and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: one beat in flight, output slot tracked here
    vdme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // stores, divider, ring and the result register
    vdme_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_beat  (i_in_beat),
        .o_out_beat (o_out_beat)
    );

endmodule
